// ===== hdl/tcs_pkg.sv =====
// Shared types and constants for the tridiagonal column solver.
`default_nettype none
package tcs_pkg;

    localparam int DATA_W = 32;
    localparam int IDX_W  = 6;

    typedef struct packed {
        logic signed [DATA_W-1:0] lower_diag;
        logic signed [DATA_W-1:0] main_diag;
        logic signed [DATA_W-1:0] upper_diag;
        logic signed [DATA_W-1:0] right_side;
        logic                     last_level;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] solution;
        logic [IDX_W-1:0]         level_index;
        logic                     final_result;
        logic                     pivot_error;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_DIV_R,
        S_MUL_A,
        S_PIV,
        S_NUM,
        S_DIVY_GO,
        S_DIV_Y,
        S_BACK_SET,
        S_BACK_REQ,
        S_BACK_CALC,
        S_BACK_SUB,
        S_EMIT
    } state_t;

    typedef enum logic [1:0] {
        MUL_A_RATIO,
        MUL_A_Y,
        MUL_R_X
    } mul_sel_t;

    typedef struct packed {
        logic     capture;
        logic     init_first;
        logic     div_start;
        logic     div_sel_y;
        logic     ratio_wr;
        logic     mul_start;
        mul_sel_t mul_sel;
        logic     pivot_upd;
        logic     num_upd;
        logic     part_wr;
        logic     back_init;
        logic     mem_rd;
        logic     x_load_top;
        logic     x_upd;
        logic     emit;
        logic     idx_dec;
        logic     col_end;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_free;
        logic count_zero;
        logic count_full;
        logic is_top;
        logic idx_zero;
        logic last;
    } sts_t;

endpackage
`default_nettype wire

// ===== hdl/tridiagonal_column_solver.sv =====
// A non-last level runs two serial divisions by the running pivot in the shared radix-2
// divider between accepts; level zero runs one. After the last level, each solution beat
// is set by the store read and the multiply-subtract of the back substitution (the top
// beat needs no multiply) and waits while the output is busy; one item is worked at a time.
// Reset clears the controller, level count, pivot, carried upper coefficient and error
// flag at once; the coefficient stores need no clearing.
`default_nettype none
module tridiagonal_column_solver
    import tcs_pkg::*;
#(
    parameter int LEVELS    = 64,
    parameter int FRAC_BITS = 16
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire in_item_t in_data,
    output logic          out_valid,
    input  wire logic     out_ready,
    output out_item_t     out_data
);

    cmd_t cmd;
    sts_t sts;

    tcs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tcs_datapath #(
        .LEVELS    (LEVELS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
`default_nettype wire

// ===== hdl/tcs_div.sv =====
// Radix-2 restoring divider for (n * 2^FRAC_BITS) / d with saturation.
`default_nettype none
module tcs_div
    import tcs_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic signed [DATA_W-1:0] num,
    input  wire logic signed [DATA_W-1:0] den,
    output logic                          done,
    output logic signed [DATA_W-1:0]      quot,
    output logic                          zero_div
);

    localparam int NW = DATA_W + FRAC_BITS;
    localparam int CNT_W = $clog2(NW + 1);
    localparam logic [NW-1:0] LIM_POS = NW'({1'b0, {(DATA_W-1){1'b1}}});
    localparam logic [NW-1:0] LIM_NEG = LIM_POS + NW'(1);

    logic              active_reg, active_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [NW-1:0]     sh_reg, sh_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] dm_reg, dm_next;
    logic              neg_reg, neg_next;
    logic              zero_reg, zero_next;
    logic              nneg_reg, nneg_next;

    logic [DATA_W-1:0] n_mag, d_mag;
    logic [DATA_W:0]   rem_sh;
    logic              ge;

    assign n_mag  = num[DATA_W-1] ? DATA_W'(-num) : DATA_W'(num);
    assign d_mag  = den[DATA_W-1] ? DATA_W'(-den) : DATA_W'(den);
    assign rem_sh = {rem_reg, sh_reg[NW-1]};
    assign ge     = rem_sh >= {1'b0, dm_reg};

    always_comb
    begin
        active_next = active_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        sh_next     = sh_reg;
        rem_next    = rem_reg;
        dm_next     = dm_reg;
        neg_next    = neg_reg;
        zero_next   = zero_reg;
        nneg_next   = nneg_reg;
        if (start)
        begin
            active_next = 1'b1;
            cnt_next    = CNT_W'(NW);
            sh_next     = {n_mag, {FRAC_BITS{1'b0}}};
            rem_next    = '0;
            dm_next     = d_mag;
            neg_next    = num[DATA_W-1] ^ den[DATA_W-1];
            zero_next   = (den == '0);
            nneg_next   = !num[DATA_W-1];
        end
        else if (active_reg)
        begin
            rem_next = ge ? DATA_W'(rem_sh - {1'b0, dm_reg}) : DATA_W'(rem_sh);
            sh_next  = {sh_reg[NW-2:0], ge};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg   <= sh_next;
        rem_reg  <= rem_next;
        dm_reg   <= dm_next;
        neg_reg  <= neg_next;
        zero_reg <= zero_next;
        nneg_reg <= nneg_next;
    end

    always_comb
    begin
        if (zero_reg)
            quot = nneg_reg ? DATA_W'(LIM_POS) : DATA_W'(LIM_NEG);
        else if (neg_reg)
            quot = (sh_reg > LIM_NEG) ? DATA_W'(LIM_NEG) : DATA_W'(-sh_reg);
        else
            quot = (sh_reg > LIM_POS) ? DATA_W'(LIM_POS) : DATA_W'(sh_reg);
    end

    assign done     = done_reg;
    assign zero_div = zero_reg;

endmodule
`default_nettype wire

// ===== hdl/tcs_datapath.sv =====
// Datapath: item registers, coefficient stores, multiplier, divider and output beat.
`default_nettype none
module tcs_datapath
    import tcs_pkg::*;
#(
    parameter int LEVELS    = 64,
    parameter int FRAC_BITS = 16
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cmd_t      cmd,
    output sts_t           sts,
    input  wire in_item_t  in_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_item_t      out_data
);

    localparam int IW = $clog2(LEVELS);
    localparam int CW = $clog2(LEVELS + 1);
    localparam logic signed [DATA_W-1:0] S_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] S_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    in_item_t item_reg;
    logic [CW-1:0] count_reg;
    logic signed [DATA_W-1:0] prev_upper_reg, pivot_reg;
    logic err_reg;
    logic signed [DATA_W-1:0] ratio_reg, y_prev_reg, tmp_reg, x_reg;
    logic [IW-1:0] idx_reg;
    logic signed [2*DATA_W-1:0] prod_reg;
    logic signed [DATA_W-1:0] part_rd_reg, ratio_rd_reg;
    logic out_valid_reg;
    out_item_t out_reg;

    logic signed [DATA_W-1:0] ratio_mem [LEVELS];
    logic signed [DATA_W-1:0] part_mem [LEVELS];

    logic signed [DATA_W-1:0] div_n, div_d, div_q, mul_a, mul_b, mul_sat;
    logic div_done, div_zero;
    logic signed [2*DATA_W-1:0] prod_sh;
    logic [CW-1:0] count_m1;
    logic [IW-1:0] wr_addr, idx_p1;

    function automatic logic signed [DATA_W-1:0] sat_sub(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        logic signed [DATA_W:0] d;
        d = {a[DATA_W-1], a} - {b[DATA_W-1], b};
        if (d[DATA_W] != d[DATA_W-1])
            return d[DATA_W] ? S_MIN : S_MAX;
        return d[DATA_W-1:0];
    endfunction

    assign div_n = cmd.div_sel_y ? tmp_reg : prev_upper_reg;
    assign div_d = pivot_reg;

    tcs_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .num      (div_n),
        .den      (div_d),
        .done     (div_done),
        .quot     (div_q),
        .zero_div (div_zero)
    );

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_A_RATIO:
            begin
                mul_a = item_reg.lower_diag;
                mul_b = ratio_reg;
            end
            MUL_A_Y:
            begin
                mul_a = item_reg.lower_diag;
                mul_b = y_prev_reg;
            end
            MUL_R_X:
            begin
                mul_a = ratio_rd_reg;
                mul_b = x_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // floor shift, then clamp to 32 bits
    assign prod_sh = prod_reg >>> FRAC_BITS;
    always_comb
    begin
        if (prod_sh[2*DATA_W-1:DATA_W-1] == '0 || prod_sh[2*DATA_W-1:DATA_W-1] == '1)
            mul_sat = prod_sh[DATA_W-1:0];
        else
            mul_sat = prod_sh[2*DATA_W-1] ? S_MIN : S_MAX;
    end

    assign count_m1 = count_reg - CW'(1);
    assign wr_addr  = count_reg[IW-1:0];
    assign idx_p1   = idx_reg + IW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            prev_upper_reg <= '0;
            pivot_reg      <= '0;
            err_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.init_first)
                pivot_reg <= item_reg.main_diag;
            else if (cmd.pivot_upd)
                pivot_reg <= sat_sub(item_reg.main_diag, mul_sat);
            if (div_done && div_zero)
                err_reg <= 1'b1;
            if (cmd.part_wr)
            begin
                prev_upper_reg <= item_reg.upper_diag;
                count_reg      <= count_reg + CW'(1);
            end
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (cmd.col_end)
            begin
                count_reg      <= '0;
                prev_upper_reg <= '0;
                pivot_reg      <= '0;
                err_reg        <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            item_reg <= in_data;
        if (cmd.init_first)
            tmp_reg <= item_reg.right_side;
        else if (cmd.num_upd)
            tmp_reg <= sat_sub(item_reg.right_side, mul_sat);
        if (cmd.ratio_wr)
            ratio_reg <= div_q;
        if (cmd.part_wr)
            y_prev_reg <= div_q;
        if (cmd.mul_start)
            prod_reg <= mul_a * mul_b;
        if (cmd.back_init)
            idx_reg <= count_m1[IW-1:0];
        else if (cmd.idx_dec)
            idx_reg <= idx_reg - IW'(1);
        if (cmd.x_load_top)
            x_reg <= part_rd_reg;
        else if (cmd.x_upd)
            x_reg <= sat_sub(part_rd_reg, mul_sat);
        if (cmd.emit)
        begin
            out_reg.solution     <= x_reg;
            out_reg.level_index  <= IDX_W'(idx_reg);
            out_reg.final_result <= (idx_reg == '0);
            out_reg.pivot_error  <= err_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ratio_wr)
            ratio_mem[wr_addr] <= div_q;
        if (cmd.mem_rd)
            ratio_rd_reg <= ratio_mem[idx_p1];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.part_wr)
            part_mem[wr_addr] <= div_q;
        if (cmd.mem_rd)
            part_rd_reg <= part_mem[idx_reg];
    end

    assign sts.div_done   = div_done;
    assign sts.out_free   = !out_valid_reg || out_ready;
    assign sts.count_zero = (count_reg == '0);
    assign sts.count_full = (count_reg == CW'(LEVELS));
    assign sts.is_top     = (idx_reg == count_m1[IW-1:0]);
    assign sts.idx_zero   = (idx_reg == '0);
    assign sts.last       = item_reg.last_level;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
`default_nettype wire

// ===== hdl/tcs_ctrl.sv =====
// Controller state machine sequencing elimination and back substitution.
`default_nettype none
module tcs_ctrl
    import tcs_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mul_sel = MUL_A_RATIO;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_LOAD;
                end
            end
            S_LOAD:
            begin
                if (!sts.count_full)
                begin
                    if (sts.count_zero)
                    begin
                        cmd.init_first = 1'b1;
                        state_next     = S_DIVY_GO;
                    end
                    else
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = S_DIV_R;
                    end
                end
                else if (sts.last)
                    state_next = S_BACK_SET;
                else
                    state_next = S_IDLE;
            end
            S_DIV_R:
            begin
                if (sts.div_done)
                begin
                    cmd.ratio_wr = 1'b1;
                    state_next   = S_MUL_A;
                end
            end
            S_MUL_A:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MUL_A_RATIO;
                state_next    = S_PIV;
            end
            S_PIV:
            begin
                cmd.pivot_upd = 1'b1;
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MUL_A_Y;
                state_next    = S_NUM;
            end
            S_NUM:
            begin
                cmd.num_upd = 1'b1;
                state_next  = S_DIVY_GO;
            end
            S_DIVY_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel_y = 1'b1;
                state_next    = S_DIV_Y;
            end
            S_DIV_Y:
            begin
                if (sts.div_done)
                begin
                    cmd.part_wr = 1'b1;
                    state_next  = sts.last ? S_BACK_SET : S_IDLE;
                end
            end
            S_BACK_SET:
            begin
                cmd.back_init = 1'b1;
                state_next    = S_BACK_REQ;
            end
            S_BACK_REQ:
            begin
                cmd.mem_rd = 1'b1;
                state_next = S_BACK_CALC;
            end
            S_BACK_CALC:
            begin
                if (sts.is_top)
                begin
                    cmd.x_load_top = 1'b1;
                    state_next     = S_EMIT;
                end
                else
                begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel   = MUL_R_X;
                    state_next    = S_BACK_SUB;
                end
            end
            S_BACK_SUB:
            begin
                cmd.x_upd  = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                // hold until the output register frees up
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (sts.idx_zero)
                    begin
                        cmd.col_end = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        cmd.idx_dec = 1'b1;
                        state_next  = S_BACK_REQ;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire
